@@ rtl/apsp_pkg.sv @@
// Shared constants, types and address helper for the shortest path unit.
package apsp_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VTX_W        = $clog2(MAX_VERTICES);
  localparam int DEPTH        = MAX_VERTICES * MAX_VERTICES;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int MARK_W       = $clog2(MAX_VERTICES + 1);
  localparam int DATA_W       = 32;
  localparam int FIELD_VTX_W  = 6;
  localparam int CFG_W        = 7;

  localparam logic signed [DATA_W-1:0] NO_EDGE  = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] MIN_DIST = 32'sh8000_0000;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic signed [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0]        raddr_a;
    logic [ADDR_W-1:0]        raddr_b;
  } dmem_req_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [MARK_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mmem_req_t;

  function automatic logic [ADDR_W-1:0] vtx_addr(input logic [VTX_W-1:0] r,
                                                 input logic [VTX_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_VERTICES) + ADDR_W'(c);
  endfunction

endpackage

@@ rtl/apsp_dist_mem.sv @@
// Distance matrix memory: one write port, two registered read ports.
module apsp_dist_mem (
  input  logic                              clk,
  input  apsp_pkg::dmem_req_t               req,
  output logic signed [apsp_pkg::DATA_W-1:0] rd_a,
  output logic signed [apsp_pkg::DATA_W-1:0] rd_b
);
  import apsp_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_a <= mem[req.raddr_a];
    rd_b <= mem[req.raddr_b];
  end

endmodule

@@ rtl/apsp_mark_mem.sv @@
// Intermediate mark memory: one write port, one registered read port.
module apsp_mark_mem (
  input  logic                        clk,
  input  apsp_pkg::mmem_req_t         req,
  output logic [apsp_pkg::MARK_W-1:0] rd
);
  import apsp_pkg::*;

  logic [MARK_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd <= mem[req.raddr];
  end

endmodule

@@ rtl/apsp_relax.sv @@
// Relaxation step: saturating path sum and strict-improvement compare.
module apsp_relax (
  input  logic signed [apsp_pkg::DATA_W-1:0] d_ik,
  input  logic signed [apsp_pkg::DATA_W-1:0] d_kj,
  input  logic signed [apsp_pkg::DATA_W-1:0] d_ij,
  output logic signed [apsp_pkg::DATA_W-1:0] cand,
  output logic                               take
);
  import apsp_pkg::*;

  logic signed [DATA_W:0] sum;

  always_comb begin
    sum = $signed({d_ik[DATA_W-1], d_ik}) + $signed({d_kj[DATA_W-1], d_kj});
    if (d_ik == NO_EDGE || d_kj == NO_EDGE) begin
      cand = NO_EDGE;
    end else if (sum > $signed({NO_EDGE[DATA_W-1], NO_EDGE})) begin
      cand = NO_EDGE;
    end else if (sum < $signed({MIN_DIST[DATA_W-1], MIN_DIST})) begin
      cand = MIN_DIST;
    end else begin
      cand = sum[DATA_W-1:0];
    end
    take = cand < d_ij;
  end

endmodule

@@ rtl/all_pairs_shortest_path_unit.sv @@
// Top level: command sequencer, matrix memories and reply register.
// Write word: no reply. Read word: the reply is loaded from S_RDATA into the reply register.
// Run word: mark clear and diagonal pass over every entry, then relaxation
//   (one per cycle on the dual-read distance memory, plus the S_IK and S_IKW states per row
//   to fetch d[i][k]), then the done reply. One word is worked at a time.
// Reset clears control state and sets vertex_count to 64; matrix contents are not cleared.
module all_pairs_shortest_path_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [6:0]          cfg_data,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  logic [1:0]          operation,
  input  logic [5:0]          from_vertex,
  input  logic [5:0]          to_vertex,
  input  logic signed [31:0]  edge_weight,
  output logic                reply_valid,
  input  logic                reply_stall,
  output logic                is_read_reply,
  output logic signed [31:0]  distance,
  output logic                has_intermediate,
  output logic [5:0]          intermediate_vertex
);
  import apsp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDATA = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_IK    = 3'd3;
  localparam logic [2:0] S_IKW   = 3'd4;
  localparam logic [2:0] S_ROW   = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;

  logic [2:0]              state;
  logic [CFG_W-1:0]        vertex_count;
  logic [VTX_W-1:0]        i, j, k;
  logic [VTX_W-1:0]        n_last;
  logic                    n_zero;
  logic                    ran;
  logic                    rd_inside;
  logic signed [DATA_W-1:0] dik;

  // relaxation pipeline: reads issued in S_ROW, evaluated and written in the cycle after
  logic                    ev_valid;
  logic [ADDR_W-1:0]       ev_addr;
  logic                    ev_hit_k;
  logic [MARK_W-1:0]       ev_mark;

  logic                    cmd_accept;
  logic                    in_range;
  logic [ADDR_W-1:0]       cmd_addr;
  logic [CNT_W-1:0]        n_use;
  logic                    sweep_end;
  logic                    diag;

  dmem_req_t               dreq;
  mmem_req_t               mreq;
  logic signed [DATA_W-1:0] rd_a, rd_b;
  logic [MARK_W-1:0]       mark_rd;
  logic signed [DATA_W-1:0] cand;
  logic                    take;

  // accept a word only when idle and the reply slot is free or draining
  assign cmd_stall  = (state != S_IDLE) || (reply_valid && reply_stall);
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign in_range   = (int'(from_vertex) < MAX_VERTICES) && (int'(to_vertex) < MAX_VERTICES);
  assign cmd_addr   = vtx_addr(VTX_W'(from_vertex), VTX_W'(to_vertex));
  assign sweep_end  = (i == VTX_W'(MAX_VERTICES - 1)) && (j == VTX_W'(MAX_VERTICES - 1));
  assign diag       = (i == j) && !n_zero && (i <= n_last);

  // clamp the vertex count to the matrix size
  always_comb begin
    if (int'(vertex_count) > MAX_VERTICES) begin
      n_use = CNT_W'(MAX_VERTICES);
    end else begin
      n_use = CNT_W'(vertex_count);
    end
  end

  apsp_relax u_relax (
    .d_ik (dik),
    .d_kj (rd_a),
    .d_ij (rd_b),
    .cand (cand),
    .take (take)
  );

  // memory port steering
  always_comb begin
    dreq.we      = 1'b0;
    dreq.waddr   = cmd_addr;
    dreq.wdata   = edge_weight;
    dreq.raddr_a = cmd_addr;
    dreq.raddr_b = vtx_addr(i, j);
    mreq.we      = 1'b0;
    mreq.waddr   = vtx_addr(i, j);
    mreq.wdata   = '0;
    mreq.raddr   = cmd_addr;
    if (state == S_IDLE) begin
      dreq.we = cmd_accept && (operation == OP_WRITE) && in_range;
    end
    if (state == S_SWEEP) begin
      // clear every mark; zero the diagonal of the active square
      mreq.we     = 1'b1;
      dreq.we     = diag;
      dreq.waddr  = vtx_addr(i, j);
      dreq.wdata  = '0;
    end
    if (state == S_IK) begin
      dreq.raddr_a = vtx_addr(i, k);
    end
    if (state == S_ROW) begin
      dreq.raddr_a = vtx_addr(k, j);
    end
    if (ev_valid && take) begin
      dreq.we    = 1'b1;
      dreq.waddr = ev_addr;
      dreq.wdata = cand;
      mreq.we    = 1'b1;
      mreq.waddr = ev_addr;
      mreq.wdata = ev_mark;
    end
  end

  apsp_dist_mem u_dist (
    .clk  (clk),
    .req  (dreq),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  apsp_mark_mem u_mark (
    .clk (clk),
    .req (mreq),
    .rd  (mark_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CFG_W'(64);
    end else if (cfg_write) begin
      vertex_count <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ran      <= 1'b0;
      ev_valid <= 1'b0;
      i        <= '0;
      j        <= '0;
      k        <= '0;
    end else begin
      ev_valid <= (state == S_ROW);
      unique case (state)
        S_IDLE: begin
          if (cmd_accept) begin
            case (operation)
              OP_RUN: begin
                ran   <= 1'b1;
                i     <= '0;
                j     <= '0;
                state <= S_SWEEP;
              end
              OP_READ: begin
                state <= S_RDATA;
              end
              default: begin
              end
            endcase
          end
        end
        S_RDATA: begin
          state <= S_IDLE;
        end
        S_SWEEP: begin
          if (sweep_end) begin
            i     <= '0;
            j     <= '0;
            k     <= '0;
            state <= n_zero ? S_DRAIN : S_IK;
          end else if (j == VTX_W'(MAX_VERTICES - 1)) begin
            j <= '0;
            i <= i + 1'b1;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_IK: begin
          state <= S_IKW;
        end
        S_IKW: begin
          state <= S_ROW;
        end
        S_ROW: begin
          if (j == n_last) begin
            j <= '0;
            if (i == n_last) begin
              i <= '0;
              if (k == n_last) begin
                state <= S_DRAIN;
              end else begin
                k     <= k + 1'b1;
                state <= S_IK;
              end
            end else begin
              i     <= i + 1'b1;
              state <= S_IK;
            end
          end else begin
            j <= j + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_accept) begin
      rd_inside <= in_range;
      n_zero    <= (n_use == '0);
      n_last    <= VTX_W'(n_use - 1'b1);
    end
    if (state == S_ROW) begin
      ev_addr  <= vtx_addr(i, j);
      ev_hit_k <= (j == k);
      ev_mark  <= MARK_W'(k) + 1'b1;
    end
    if (state == S_IKW) begin
      dik <= rd_a;
    end else if (ev_valid && take && ev_hit_k) begin
      // forward the new d[i][k] to the rest of the row
      dik <= cand;
    end
  end

  // reply register
  always_ff @(posedge clk) begin
    if (rst) begin
      reply_valid <= 1'b0;
    end else if (state == S_RDATA || state == S_DRAIN) begin
      reply_valid <= 1'b1;
    end else if (reply_valid && !reply_stall) begin
      reply_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RDATA) begin
      is_read_reply       <= 1'b1;
      distance            <= rd_inside ? rd_a : NO_EDGE;
      has_intermediate    <= rd_inside && ran && (mark_rd != '0);
      intermediate_vertex <= (rd_inside && ran && (mark_rd != '0)) ?
                             6'(mark_rd - 1'b1) : 6'd0;
    end else if (state == S_DRAIN) begin
      is_read_reply       <= 1'b0;
      distance            <= '0;
      has_intermediate    <= 1'b0;
      intermediate_vertex <= 6'd0;
    end
  end

  a_ev_in_run: assert property (@(posedge clk) disable iff (rst)
    ev_valid |-> (state == S_IK || state == S_ROW || state == S_DRAIN))
    else $error("relaxation write outside a run");

  a_rdata_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDATA || state == S_DRAIN) |-> !reply_valid)
    else $error("reply loaded over an untaken reply");

  a_run_starts_sweep: assert property (@(posedge clk) disable iff (rst)
    (cmd_accept && operation == OP_RUN) |=> (state == S_SWEEP && i == '0 && j == '0))
    else $error("run did not start the clear pass at entry zero");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROW) |=> (cmd_stall && !reply_valid))
    else $error("input open or reply pending during relaxation");

endmodule

@@ test/tb_all_pairs_shortest_path_unit.sv @@
// Testbench for the all-pairs shortest path unit: self-checking with a software predictor.
`timescale 1ns / 100ps

module tb_all_pairs_shortest_path_unit;
  import apsp_pkg::*;

  localparam logic [1:0] OP_IGNORED = 2'd3;  // no operation defined, no reply
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 20;         // write words give no reply; let them drain

  typedef struct {
    logic              is_read;
    logic signed [31:0] dist_val;
    logic              has_mid;
    logic [5:0]        mid;
  } reply_t;

  logic clk, rst;
  logic cfg_write;
  logic [6:0] cfg_data;
  logic cmd_valid, cmd_stall;
  logic [1:0] operation;
  logic [5:0] from_vertex, to_vertex;
  logic signed [31:0] edge_weight;
  logic reply_valid, reply_stall;
  logic is_read_reply;
  logic signed [31:0] distance;
  logic has_intermediate;
  logic [5:0] intermediate_vertex;

  all_pairs_shortest_path_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .operation(operation), .from_vertex(from_vertex), .to_vertex(to_vertex),
    .edge_weight(edge_weight),
    .reply_valid(reply_valid), .reply_stall(reply_stall),
    .is_read_reply(is_read_reply), .distance(distance),
    .has_intermediate(has_intermediate), .intermediate_vertex(intermediate_vertex)
  );

  // Predictor state: distance and mark per pair (mark 0 = none, else k+1),
  // plus a map of which entries hold a written value.
  logic signed [31:0] dist_mem [DEPTH];
  int                 mark_mem [DEPTH];
  bit                 written  [DEPTH];
  logic [6:0]         vtx_count;

  reply_t pending_replies[$];
  int errors = 0;
  int cycles = 0;
  bit burst = 0;        // when set, the sender offers back to back
  bit press_req = 0;    // asks the receiver for one long hold-off
  int hold_left = 0;
  int stall_left = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a correct run ends far below this.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic signed [31:0] sat_sum(logic signed [31:0] a,
                                                 logic signed [31:0] b);
    longint s;
    if (a == NO_EDGE || b == NO_EDGE) return NO_EDGE;
    s = longint'(a) + longint'(b);
    if (s > longint'(NO_EDGE)) return NO_EDGE;
    if (s < longint'(MIN_DIST)) return MIN_DIST;
    return s[31:0];
  endfunction

  // Floyd-Warshall over the vertices in use, recording the last improving k.
  task automatic relax_all_pairs();
    int n;
    logic signed [31:0] cand;
    n = (vtx_count > MAX_VERTICES) ? MAX_VERTICES : vtx_count;
    for (int i = 0; i < n; i++) begin
      dist_mem[i*MAX_VERTICES+i] = 0;
      written[i*MAX_VERTICES+i] = 1;
    end
    foreach (mark_mem[a]) mark_mem[a] = 0;
    for (int k = 0; k < n; k++)
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          cand = sat_sum(dist_mem[i*MAX_VERTICES+k], dist_mem[k*MAX_VERTICES+j]);
          if (cand < dist_mem[i*MAX_VERTICES+j]) begin
            dist_mem[i*MAX_VERTICES+j] = cand;
            mark_mem[i*MAX_VERTICES+j] = k + 1;
          end
        end
  endtask

  // Apply one accepted word to the predictor and queue its reply, if any.
  task automatic predict_word(logic [1:0] op, logic [5:0] f, logic [5:0] t,
                              logic signed [31:0] w);
    reply_t r;
    int a;
    a = f * MAX_VERTICES + t;
    case (op)
      OP_WRITE: begin
        dist_mem[a] = w;
        written[a] = 1;
      end
      OP_RUN: begin
        relax_all_pairs();
        r = '{1'b0, 32'sd0, 1'b0, 6'd0};
        pending_replies = {pending_replies, r};
      end
      OP_READ: begin
        r.is_read = 1'b1;
        r.dist_val = dist_mem[a];
        r.has_mid = mark_mem[a] != 0;
        r.mid = (mark_mem[a] != 0) ? 6'(mark_mem[a] - 1) : 6'd0;
        pending_replies = {pending_replies, r};
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one word; return after the edge that accepts it. Valid stays high
  // so a following word can go out with no bubble.
  task automatic send_word(logic [1:0] op, logic [5:0] f, logic [5:0] t,
                           logic signed [31:0] w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    operation <= op;
    from_vertex <= f;
    to_vertex <= t;
    edge_weight <= w;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    predict_word(op, f, t, w);
  endtask

  // Hold until every reply is in, then let write words drain.
  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(logic [6:0] v);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    vtx_count = v;
  endtask

  function automatic logic signed [31:0] pick_weight();
    case ($urandom_range(0, 7))
      0: return NO_EDGE;
      1: return $urandom;
      2: return -$signed(32'($urandom_range(0, 50)));
      3: return MIN_DIST;
      default: return $urandom_range(0, 100);
    endcase
  endfunction

  // Load every pair among the first n vertices.
  task automatic load_square(int n);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        send_word(OP_WRITE, 6'(i), 6'(j), pick_weight());
  endtask

  // Read a random entry that holds a written value.
  task automatic read_written();
    int a;
    do a = $urandom_range(0, DEPTH - 1); while (!written[a]);
    send_word(OP_READ, 6'(a / MAX_VERTICES), 6'(a % MAX_VERTICES), 32'sd0);
  endtask

  // Receiver: check each accepted reply against the oldest prediction and
  // choose the next stall state.
  always @(posedge clk) begin
    reply_t e;
    if (!rst && reply_valid && !reply_stall) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply is_read=%0b dist=%0d", $time, is_read_reply,
                 distance);
        errors++;
      end else begin
        e = pending_replies.pop_front();
        if (is_read_reply !== e.is_read || distance !== e.dist_val ||
            has_intermediate !== e.has_mid || intermediate_vertex !== e.mid) begin
          $display("%0t: expected read=%0b dist=%0d mid=%0b/%0d, got read=%0b dist=%0d mid=%0b/%0d",
                   $time, e.is_read, e.dist_val, e.has_mid, e.mid, is_read_reply, distance,
                   has_intermediate, intermediate_vertex);
          errors++;
        end
      end
    end
    if (press_req) begin
      hold_left = 300;
      press_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      reply_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      reply_stall <= 1'b1;
    end else begin
      reply_stall <= 1'b0;
      if ($urandom_range(0, 99) < 15)
        stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                 : $urandom_range(10, 50);
    end
  end

  // Zero vertices, one vertex, and the edge-value extremes on a small graph.
  task automatic test_directed();
    set_vertex_count(7'd0);
    send_word(OP_RUN, 6'd0, 6'd0, 32'sd0);
    drain();
    set_vertex_count(7'd1);
    send_word(OP_WRITE, 6'd0, 6'd0, NO_EDGE);
    send_word(OP_READ, 6'd0, 6'd0, 32'sd0);      // read after the zero-vertex run: marks are clear
    send_word(OP_RUN, 6'd0, 6'd0, 32'sd0);
    send_word(OP_READ, 6'd0, 6'd0, 32'sd0);
    drain();
    set_vertex_count(7'd3);
    send_word(OP_WRITE, 6'd0, 6'd1, MIN_DIST);
    send_word(OP_WRITE, 6'd1, 6'd2, -32'sd1);     // low saturation via 0->1->2
    send_word(OP_WRITE, 6'd0, 6'd2, 32'sd5);
    send_word(OP_WRITE, 6'd1, 6'd0, 32'sh7FFF_FFFE);
    send_word(OP_WRITE, 6'd2, 6'd0, 32'sd1);      // large sum overflows to no edge
    send_word(OP_WRITE, 6'd2, 6'd1, NO_EDGE);
    send_word(OP_WRITE, 6'd63, 6'd63, -32'sd7);   // outside the graph, all ones vertex
    send_word(OP_WRITE, 6'd42, 6'd21, 32'sd9);
    send_word(OP_IGNORED, 6'd63, 6'd0, 32'shFFFF_FFFF);
    send_word(OP_RUN, 6'd0, 6'd0, 32'sd0);
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        send_word(OP_READ, 6'(a), 6'(b), 32'sd0);
    send_word(OP_READ, 6'd63, 6'd63, 32'sd0);
    send_word(OP_READ, 6'd42, 6'd21, 32'sd0);
    drain();
  endtask

  // Random phases on small graphs: mostly well-formed load/run/read, some noise.
  task automatic test_random();
    int n;
    for (int phase = 0; phase < 3; phase++) begin
      n = (phase == 0) ? 2 : $urandom_range(1, 4);
      set_vertex_count(7'(n));
      burst = (phase == 2);
      load_square(n);
      for (int it = 0; it < 12; it++) begin
        case ($urandom_range(0, 9))
          0, 1: send_word(OP_WRITE, 6'($urandom_range(0, n - 1)),
                          6'($urandom_range(0, n - 1)), pick_weight());
          2: send_word(OP_WRITE, 6'($urandom), 6'($urandom), $urandom);
          3: send_word(OP_RUN, 6'($urandom), 6'($urandom), $urandom);
          4: send_word(OP_IGNORED, 6'($urandom), 6'($urandom), $urandom);
          default: read_written();
        endcase
      end
      send_word(OP_RUN, 6'd0, 6'd0, 32'sd0);
      repeat (2) read_written();
      drain();
    end
    burst = 0;
  endtask

  // Receiver holds off while reads keep coming: the unit must stall its input.
  task automatic test_backpressure();
    press_req = 1;
    burst = 1;
    repeat (20) read_written();
    burst = 0;
    drain();
  endtask

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data <= 7'd0;
    cmd_valid <= 1'b0;
    operation <= OP_WRITE;
    from_vertex <= 6'd0;
    to_vertex <= 6'd0;
    edge_weight <= 32'sd0;
    reply_stall <= 1'b0;
    foreach (dist_mem[a]) begin
      dist_mem[a] = 0;
      mark_mem[a] = 0;
      written[a] = 0;
    end
    vtx_count = 7'd64;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random();
    test_backpressure();

    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/apsp_pkg.sv
rtl/apsp_dist_mem.sv
rtl/apsp_mark_mem.sv
rtl/apsp_relax.sv
rtl/all_pairs_shortest_path_unit.sv
test/tb_all_pairs_shortest_path_unit.sv
